// ===== design/spt_pkg.sv =====
// Shared types, field widths and command codes of the sorted priority table.
`default_nettype none
package spt_pkg;

  localparam int SPT_DEPTH = 16;

  localparam int CMD_W  = 3;
  localparam int PR_W   = 2;
  localparam int PG_W   = 16;
  localparam int ID_W   = 16;
  localparam int CNT_OW = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_CHECK  = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Source of the fields loaded into the output register.
  typedef enum logic [2:0] {
    EM_NEW  = 3'd0,
    EM_HIT  = 3'd1,
    EM_FAIL = 3'd2,
    EM_HEAD = 3'd3,
    EM_ZERO = 3'd4
  } emit_sel_t;

  typedef struct packed {
    logic [PR_W-1:0] pr;
    logic [PG_W-1:0] pg;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic      capture;
    logic      relook;
    logic      insert;
    logic      remove;
    logic      rotate;
    logic      emit;
    emit_sel_t sel;
    status_t   code;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic dump_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/spt_ctrl.sv =====
// Controller state machine that sequences each command over the datapath.
`default_nettype none
module spt_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spt_pkg::CMD_W-1:0]    in_command,
  input  spt_pkg::dp_stat_t            stat,
  output spt_pkg::dp_cmd_t             cmd
);
  import spt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ACT    = 5'b00010,
    S_RELOOK = 5'b00100,
    S_REINS  = 5'b01000,
    S_DUMP   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cmd       = '0;
    cmd.sel   = EM_ZERO;
    cmd.code  = ST_OK;
    cmd.last  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd_nxt     = in_command;
          state_nxt   = S_ACT;
        end
      end
      S_ACT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
          cmd.emit  = 1'b1;
          unique case (cmd_r)
            CMD_INSERT: begin
              if (stat.full) begin
                cmd.sel  = EM_FAIL;
                cmd.code = ST_FULL;
              end else begin
                cmd.insert = 1'b1;
                cmd.sel    = EM_NEW;
              end
            end
            CMD_REMOVE, CMD_CHECK, CMD_UPDATE: begin
              if (stat.empty) begin
                cmd.sel  = EM_FAIL;
                cmd.code = ST_EMPTY;
              end else if (!stat.found) begin
                cmd.sel  = EM_FAIL;
                cmd.code = ST_NOT_FOUND;
              end else if (cmd_r == CMD_UPDATE) begin
                // The entry leaves now and comes back by the insert rule.
                cmd.remove = 1'b1;
                cmd.emit   = 1'b0;
                state_nxt  = S_RELOOK;
              end else begin
                cmd.remove = (cmd_r == CMD_REMOVE);
                cmd.sel    = EM_HIT;
              end
            end
            CMD_DUMP: begin
              if (stat.empty) begin
                cmd.sel  = EM_FAIL;
                cmd.code = ST_EMPTY;
              end else begin
                cmd.emit  = 1'b0;
                state_nxt = S_DUMP;
              end
            end
            default: cmd.sel = EM_ZERO;
          endcase
        end
      end
      S_RELOOK: begin
        cmd.relook = 1'b1;
        state_nxt  = S_REINS;
      end
      S_REINS: begin
        if (stat.out_free) begin
          cmd.insert = 1'b1;
          cmd.emit   = 1'b1;
          cmd.sel    = EM_NEW;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_HEAD;
          cmd.rotate = 1'b1;
          cmd.last   = stat.dump_last;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ===== design/spt_dpath.sv =====
// Datapath: sorted row of entry cells, compare vectors, count and output register.
`default_nettype none
module spt_dpath #(
  parameter int DEPTH = spt_pkg::SPT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spt_pkg::dp_cmd_t             cmd,
  output spt_pkg::dp_stat_t            stat,
  input  logic [spt_pkg::PR_W-1:0]     in_new_priority,
  input  logic [spt_pkg::PG_W-1:0]     in_page_count,
  input  logic [spt_pkg::ID_W-1:0]     in_entry_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [spt_pkg::PR_W-1:0]     out_priority,
  output logic [spt_pkg::PG_W-1:0]     out_pages,
  output logic [spt_pkg::ID_W-1:0]     out_id,
  output logic [spt_pkg::CNT_OW-1:0]   out_entry_count,
  output logic                         out_last
);
  import spt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  entry_t            cell_r   [DEPTH];
  entry_t            cell_nxt [DEPTH];
  entry_t            key_r;
  entry_t            hit;
  entry_t            res;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     dump_idx_r;
  logic [DEPTH-1:0]  gt_r, gt_nxt;
  logic [DEPTH-1:0]  match_r, match_nxt;
  logic [DEPTH-1:0]  pre;
  logic [DEPTH-1:0]  first;
  logic [PR_W-1:0]   key_src;
  logic              out_free;
  logic              out_valid_r;
  status_t           out_status_r;
  entry_t            out_entry_r;
  logic [CNT_OW-1:0] out_count_r;
  logic              out_last_r;

  assign key_src = cmd.capture ? in_new_priority : key_r.pr;

  // Prefix OR of the match vector in log steps; first marks the earliest match.
  always_comb begin
    pre = match_r;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      pre = pre | (pre << s);
    end
    first = match_r & ~(pre << 1);
  end

  always_comb begin
    hit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit = hit | (cell_r[i] & {$bits(entry_t){first[i]}});
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;
    logic occ;
    logic prev_gt;
    logic wrap;

    assign occ          = CW'(i) < count_r;
    assign gt_nxt[i]    = occ && (cell_r[i].pr > key_src);
    assign match_nxt[i] = occ && (cell_r[i].id == in_entry_id);
    assign prev_gt      = (i == 0) ? 1'b1 : gt_r[PREV];
    assign wrap         = CW'(i) == (count_r - CW'(1));

    always_comb begin
      priority if (cmd.insert && !gt_r[i]) begin
        cell_nxt[i] = prev_gt ? key_r : cell_r[PREV];
      end else if (cmd.remove && pre[i]) begin
        cell_nxt[i] = cell_r[NEXT];
      end else if (cmd.rotate) begin
        cell_nxt[i] = wrap ? cell_r[0] : cell_r[NEXT];
      end else begin
        cell_nxt[i] = cell_r[i];
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    priority if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      EM_NEW:  res = key_r;
      EM_HIT:  res = hit;
      EM_HEAD: res = cell_r[0];
      default: res = '0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.found     = |match_r;
  assign stat.dump_last = (CW'(dump_idx_r) == (count_r - CW'(1)));
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.capture) begin
        dump_idx_r <= '0;
      end else if (cmd.rotate) begin
        dump_idx_r <= dump_idx_r + IW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r   <= '{pr: in_new_priority, pg: in_page_count, id: in_entry_id};
      match_r <= match_nxt;
    end
    if (cmd.capture || cmd.relook) begin
      gt_r <= gt_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      out_entry_r  <= res;
      out_count_r  <= CNT_OW'(count_nxt);
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_priority    = out_entry_r.pr;
  assign out_pages       = out_entry_r.pg;
  assign out_id          = out_entry_r.id;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ===== design/sorted_priority_table.sv =====
// Insert, remove, check, other: the result is loaded into the output register from
// the act state. Update: remove, re-evaluate the insert point, insert. Dump: the act
// state, then one result per held entry; a stalled out_ready stretches any of these.
// One command at a time: the next input transfer is taken the cycle after the final
// result of the previous one is loaded.
// Synchronous active-low reset empties the table; entry contents are not cleared.
`default_nettype none
module sorted_priority_table #(
  parameter int DEPTH = spt_pkg::SPT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spt_pkg::CMD_W-1:0]    in_command,
  input  logic [spt_pkg::PR_W-1:0]     in_new_priority,
  input  logic [spt_pkg::PG_W-1:0]     in_page_count,
  input  logic [spt_pkg::ID_W-1:0]     in_entry_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [spt_pkg::PR_W-1:0]     out_priority,
  output logic [spt_pkg::PG_W-1:0]     out_pages,
  output logic [spt_pkg::ID_W-1:0]     out_id,
  output logic [spt_pkg::CNT_OW-1:0]   out_entry_count,
  output logic                         out_last
);
  import spt_pkg::*;

  // The controller only sequences; all entry storage, the sorted insert and
  // delete shifts, and the output register live in the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  spt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath keeps entries in cells ordered by descending priority. A
  // command's compare vectors are registered at the input transfer, and the
  // shift that inserts or deletes happens once the output register is free. A dump
  // rotates the occupied cells so that each entry in turn reaches the head.
  spt_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_new_priority (in_new_priority),
    .in_page_count   (in_page_count),
    .in_entry_id     (in_entry_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_pages       (out_pages),
    .out_id          (out_id),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  // A failed command reports zero entry fields and marks its result as the last.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      out_last && (out_priority == '0) && (out_pages == '0) && (out_id == '0))
    else $error("failed command reported entry data");

  // Only a dump of a non-empty table gives more than one result.
  a_multi_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_status == ST_OK))
    else $error("non-final result carries an error status");

  // A rejected insert must see the table at its full count.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_entry_count == CNT_OW'(DEPTH)))
    else $error("full status with a count below the depth");

  // After an input transfer the block works on that command before taking another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transfer taken while busy");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted priority table, built around a mirrored copy of the table.
`timescale 1ns / 1ps

module testbench;
  import spt_pkg::*;

  // Percent of cycles the result side holds off while idling is enabled; commands use twice it.
  localparam int IDLE_PCT = 12;
  localparam int RANDOM_ITEMS = 352;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_LIMIT = 40;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_DUMP + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
  localparam logic [PR_W-1:0] PRI_MAX = '1;
  localparam logic [PG_W-1:0] PAGES_MAX = '1;
  localparam logic [ID_W-1:0] ID_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [PR_W-1:0] in_new_priority = '0;
  logic [PG_W-1:0] in_page_count = '0;
  logic [ID_W-1:0] in_entry_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [PR_W-1:0] out_priority;
  logic [PG_W-1:0] out_pages;
  logic [ID_W-1:0] out_id;
  logic [CNT_OW-1:0] out_entry_count;
  logic out_last;

  // When set, neither side idles; the random phase clears it outside one long stretch.
  logic calm = 1'b0;

  always #5 clk = ~clk;

  sorted_priority_table u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_new_priority(in_new_priority),
    .in_page_count(in_page_count),
    .in_entry_id(in_entry_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_priority(out_priority),
    .out_pages(out_pages),
    .out_id(out_id),
    .out_entry_count(out_entry_count),
    .out_last(out_last)
  );

  // One reply as it leaves the block.
  typedef struct {
    status_t status;
    entry_t fields;
    logic [CNT_OW-1:0] count;
    logic last;
  } reply_t;

  // Mirror of the table contents. Every accepted command is applied to the mirror,
  // and the replies the command must produce are queued in order.
  class priority_table_mirror;
    entry_t slots[SPT_DEPTH];
    int held;
    reply_t awaited_replies[$];
    int mismatch_count;
    int replies_seen;

    function new();
      held = 0;
      mismatch_count = 0;
      replies_seen = 0;
    endfunction

    task flag_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    function void await_reply(status_t st, entry_t e, logic fin);
      reply_t r;
      r.status = st;
      r.fields = e;
      r.count = held[CNT_OW-1:0];
      r.last = fin;
      awaited_replies.push_back(r);
    endfunction

    function int locate(logic [ID_W-1:0] id);
      for (int i = 0; i < held; i++)
        if (slots[i].id == id) return i;
      return -1;
    endfunction

    // Goes ahead of the first entry whose priority is not greater.
    function void place(entry_t e);
      int at;
      at = 0;
      while (at < held && slots[at].pr > e.pr) at++;
      for (int i = held; i > at; i--) slots[i] = slots[i-1];
      slots[at] = e;
      held++;
    endfunction

    function void take_out(int at);
      for (int i = at; i + 1 < held; i++) slots[i] = slots[i+1];
      held--;
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, logic [PR_W-1:0] pr,
                                logic [PG_W-1:0] pg, logic [ID_W-1:0] id);
      int at;
      entry_t hit;
      entry_t blank;
      blank = '0;
      case (cmd)
        CMD_INSERT: begin
          if (held >= SPT_DEPTH) begin
            await_reply(ST_FULL, blank, 1'b1);
          end else begin
            hit = '{pr: pr, pg: pg, id: id};
            place(hit);
            await_reply(ST_OK, hit, 1'b1);
          end
        end
        CMD_REMOVE, CMD_CHECK, CMD_UPDATE: begin
          at = locate(id);
          if (held == 0) begin
            await_reply(ST_EMPTY, blank, 1'b1);
          end else if (at < 0) begin
            await_reply(ST_NOT_FOUND, blank, 1'b1);
          end else begin
            hit = slots[at];
            if (cmd != CMD_CHECK) take_out(at);
            // An update keeps the id and is placed again by the insert rule.
            if (cmd == CMD_UPDATE) begin
              hit = '{pr: pr, pg: pg, id: hit.id};
              place(hit);
            end
            await_reply(ST_OK, hit, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (held == 0) await_reply(ST_EMPTY, blank, 1'b1);
          for (int i = 0; i < held; i++) await_reply(ST_OK, slots[i], i == held - 1);
        end
        default: await_reply(ST_OK, blank, 1'b1);
      endcase
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag_mismatch($sformatf("reply %0d field %s: got %0h, want %0h",
                                replies_seen, name, got, want));
    endtask

    task match_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        flag_mismatch($sformatf("reply %0d arrived with none outstanding", replies_seen));
      end else begin
        want = awaited_replies.pop_front();
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("priority", 32'(got.fields.pr), 32'(want.fields.pr));
        compare_field("pages", 32'(got.fields.pg), 32'(want.fields.pg));
        compare_field("id", 32'(got.fields.id), 32'(want.fields.id));
        compare_field("entry_count", 32'(got.count), 32'(want.count));
        compare_field("last", 32'(got.last), 32'(want.last));
      end
      replies_seen++;
    endtask
  endclass

  priority_table_mirror mirror = new();

  // Result side: out_ready drops in IDLE_PCT percent of cycles unless idling is off.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Values read here are the ones that stood before the edge, so the transfer is
  // judged exactly as the block sees it.
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.fields = '{pr: out_priority, pg: out_pages, id: out_id};
      got.count = out_entry_count;
      got.last = out_last;
      mirror.match_reply(got);
    end
  end

  // Presents one command and returns at the edge that transfers it. A hold-off,
  // when one is drawn, lowers valid first; otherwise valid stays high and only the
  // payload changes, so valid gets a single assignment in this time step.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [PR_W-1:0] pr,
                               input logic [PG_W-1:0] pg, input logic [ID_W-1:0] id);
    if (!calm && $urandom_range(99) < 2 * IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_new_priority <= pr;
    in_page_count <= pg;
    in_entry_id <= id;
    do @(posedge clk); while (!in_ready);
    mirror.apply_command(cmd, pr, pg, id);
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] id_pool[20];
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] id;
    int roll;
    int insert_share;
    int remove_share;
    int waited;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every command that needs an entry is tried on the empty table first.
    issue_command(CMD_DUMP, '0, '0, '0);
    issue_command(CMD_REMOVE, '0, '0, '0);
    issue_command(CMD_CHECK, PRI_MAX, PAGES_MAX, ID_MAX);
    issue_command(CMD_UPDATE, PRI_MAX, PAGES_MAX, '0);

    // Unused command codes change nothing and answer with a plain ok.
    issue_command(CMD_FIRST_UNUSED, PRI_MAX, PAGES_MAX, ID_MAX);
    issue_command(CMD_LAST_CODE, '0, '0, '0);

    // Fill the table with a mix of equal priorities, each new entry going ahead of the
    // earlier ones of its priority, field extremes and repeated ids.
    issue_command(CMD_INSERT, '0, '0, '0);
    issue_command(CMD_INSERT, PRI_MAX, PAGES_MAX, ID_MAX);
    for (int i = 2; i < SPT_DEPTH; i++)
      issue_command(CMD_INSERT, PR_W'(i * 3), PG_W'($urandom),
                    (i == SPT_DEPTH - 2) ? '0 : ID_W'(i * 16'h1111));

    // A full table rejects an insert, but an update still fits.
    issue_command(CMD_INSERT, PRI_MAX, PAGES_MAX, ID_MAX);
    issue_command(CMD_UPDATE, '0, PAGES_MAX, ID_MAX);
    issue_command(CMD_DUMP, '0, '0, '0);

    // Repeated id: the first match in table order answers. Then a miss.
    issue_command(CMD_CHECK, '0, '0, '0);
    issue_command(CMD_REMOVE, '0, '0, '0);
    issue_command(CMD_REMOVE, '0, '0, 16'h1234);

    // A small id pool keeps hits frequent; both id extremes are in it.
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (int i = 2; i < 20; i++) id_pool[i] = ID_W'($urandom);

    // Random phase in blocks of forty that alternately lean toward filling and
    // draining the table, so both the full and the empty table come up often.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 150 && k < 250);
      insert_share = ((k / 40) % 2 == 0) ? 45 : 15;
      remove_share = ((k / 40) % 2 == 0) ? 12 : 40;
      id = ($urandom_range(99) < 90) ? id_pool[$urandom_range(19)] : ID_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 4) begin
        issue_command(CMD_W'($urandom), PR_W'($urandom), PG_W'($urandom), ID_W'($urandom));
      end else if (roll < 7) begin
        issue_command(CMD_W'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED)),
                      PR_W'($urandom), PG_W'($urandom), id);
      end else begin
        roll = $urandom_range(99);
        if (roll < insert_share)
          cmd = CMD_INSERT;
        else if (roll < insert_share + remove_share)
          cmd = CMD_REMOVE;
        else if (roll < insert_share + remove_share + 15)
          cmd = CMD_CHECK;
        else if (roll < insert_share + remove_share + 30)
          cmd = CMD_UPDATE;
        else
          cmd = CMD_DUMP;
        issue_command(cmd, PR_W'($urandom), PG_W'($urandom), id);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let the outstanding replies drain, then give stray replies time to show up.
    waited = 0;
    while (mirror.awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.awaited_replies.size() != 0)
      mirror.flag_mismatch($sformatf("%0d replies never arrived",
                                     mirror.awaited_replies.size()));

    if (mirror.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
